[rtl/core/ibq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_pkg
// shared types, constants and the step sequence of the inverse bilinear solver
// ----------------------------------------------------------------------------
package ibq_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OPND_W          = 33;
  localparam int unsigned PROD_W          = 66;
  localparam int unsigned WIDE_W          = 64;
  localparam int unsigned ACC_W           = 35;
  localparam int unsigned ITER_W          = 7;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned CFG_IDX_W       = 4;
  localparam int unsigned NUM_CORNER_REGS = 8;
  localparam int unsigned PC_W            = 7;

  // result codes
  localparam logic [STATUS_W-1:0] RES_CONVERGED = 2'd0;
  localparam logic [STATUS_W-1:0] RES_LIMIT     = 2'd1;
  localparam logic [STATUS_W-1:0] RES_SINGULAR  = 2'd2;

  // step sequence layout
  localparam logic [PC_W-1:0] PC_JAC  = 7'd15;
  localparam logic [PC_W-1:0] PC_RES2 = 7'd46;
  localparam logic [PC_W-1:0] PC_ERR  = 7'd61;

  localparam logic signed [PROD_W-1:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_LO = -66'sd2147483648;

  typedef enum logic [2:0] {
    A_CORNER, A_SM, A_SP, A_X, A_Y, A_DXDS, A_DYDS
  } asel_e;

  typedef enum logic [3:0] {
    B_TM, B_TP, B_NTM, B_NTP, B_SM, B_NSM, B_SP, B_NSP,
    B_W, B_DYDT, B_DXDT, B_X, B_Y
  } bsel_e;

  typedef enum logic [1:0] {ACC_NONE, ACC_SET, ACC_ADD} accop_e;

  typedef enum logic [4:0] {
    WR_NONE, WR_FACT, WR_W, WR_X, WR_Y,
    WR_DXDS, WR_DYDS, WR_DXDT, WR_DYDT,
    WR_DET_SET, WR_DET_SUB, WR_NS_SET, WR_NS_SUB, WR_NT_SET, WR_NT_SUB,
    WR_ERR_SET, WR_ERR_ADD, WR_UPD_S, WR_UPD_T
  } wrop_e;

  typedef enum logic [2:0] {
    FL_NEXT, FL_DETCHK, FL_DIV_S, FL_DIV_T, FL_ERRCHK
  } flow_e;

  typedef struct packed {
    logic        mul_en;
    asel_e       a_sel;
    bsel_e       b_sel;
    logic [2:0]  cidx;
    accop_e      acc_op;
    wrop_e       wr_op;
    logic [1:0]  widx;
    flow_e       flow;
  } uop_t;

  typedef struct packed {
    logic                load;
    uop_t                uop;
    logic                div_start;
    logic                div_sel;
    logic                cap;
    logic [STATUS_W-1:0] status;
    logic [ITER_W-1:0]   iter;
  } dp_cmd_t;

  typedef struct packed {
    logic det_bad;
    logic err_ok;
    logic div_done;
    logic div_busy;
  } dp_stat_t;

  localparam uop_t UOP_NOP = '{mul_en: 1'b0, a_sel: A_X, b_sel: B_X, cidx: 3'd0,
                               acc_op: ACC_NONE, wr_op: WR_NONE, widx: 2'd0,
                               flow: FL_NEXT};

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) r = 32'sh7fff_ffff;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = $signed(v[DATA_W-1:0]);
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] ext66(input logic signed [DATA_W-1:0] v);
    return $signed({{(PROD_W-DATA_W){v[DATA_W-1]}}, v});
  endfunction

  function automatic uop_t mk_uop(input logic mul_en, input asel_e a, input bsel_e b,
                                  input logic [2:0] ci, input accop_e acc,
                                  input wrop_e wr, input logic [1:0] wi, input flow_e fl);
    uop_t u;
    u.mul_en = mul_en;
    u.a_sel  = a;
    u.b_sel  = b;
    u.cidx   = ci;
    u.acc_op = acc;
    u.wr_op  = wr;
    u.widx   = wi;
    u.flow   = fl;
    return u;
  endfunction

  // residual at the current s,t: factors, bilinear weights, two shape sums
  function automatic uop_t res_uop(input logic [3:0] r);
    uop_t u;
    case (r)
      4'd0:  u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_FACT, 2'd0, FL_NEXT);
      4'd1:  u = mk_uop(1'b1, A_SM, B_TM, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_NEXT);
      4'd2:  u = mk_uop(1'b1, A_SM, B_TP, 3'd0, ACC_NONE, WR_W, 2'd0, FL_NEXT);
      4'd3:  u = mk_uop(1'b1, A_SP, B_TP, 3'd0, ACC_NONE, WR_W, 2'd1, FL_NEXT);
      4'd4:  u = mk_uop(1'b1, A_SP, B_TM, 3'd0, ACC_NONE, WR_W, 2'd2, FL_NEXT);
      4'd5:  u = mk_uop(1'b1, A_CORNER, B_W, 3'd0, ACC_NONE, WR_W, 2'd3, FL_NEXT);
      4'd6:  u = mk_uop(1'b1, A_CORNER, B_W, 3'd2, ACC_SET, WR_NONE, 2'd0, FL_NEXT);
      4'd7:  u = mk_uop(1'b1, A_CORNER, B_W, 3'd4, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd8:  u = mk_uop(1'b1, A_CORNER, B_W, 3'd6, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd9:  u = mk_uop(1'b1, A_CORNER, B_W, 3'd1, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd10: u = mk_uop(1'b1, A_CORNER, B_W, 3'd3, ACC_SET, WR_X, 2'd0, FL_NEXT);
      4'd11: u = mk_uop(1'b1, A_CORNER, B_W, 3'd5, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd12: u = mk_uop(1'b1, A_CORNER, B_W, 3'd7, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd13: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      4'd14: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_Y, 2'd0, FL_NEXT);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

  // jacobian, determinant, numerators and the two divisions
  function automatic uop_t jac_uop(input logic [4:0] j);
    uop_t u;
    case (j)
      5'd0:  u = mk_uop(1'b1, A_CORNER, B_NTM, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_NEXT);
      5'd1:  u = mk_uop(1'b1, A_CORNER, B_NTP, 3'd2, ACC_SET, WR_NONE, 2'd0, FL_NEXT);
      5'd2:  u = mk_uop(1'b1, A_CORNER, B_TP, 3'd4, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd3:  u = mk_uop(1'b1, A_CORNER, B_TM, 3'd6, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd4:  u = mk_uop(1'b1, A_CORNER, B_NTM, 3'd1, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd5:  u = mk_uop(1'b1, A_CORNER, B_NTP, 3'd3, ACC_SET, WR_DXDS, 2'd0, FL_NEXT);
      5'd6:  u = mk_uop(1'b1, A_CORNER, B_TP, 3'd5, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd7:  u = mk_uop(1'b1, A_CORNER, B_TM, 3'd7, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd8:  u = mk_uop(1'b1, A_CORNER, B_NSM, 3'd0, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd9:  u = mk_uop(1'b1, A_CORNER, B_SM, 3'd2, ACC_SET, WR_DYDS, 2'd0, FL_NEXT);
      5'd10: u = mk_uop(1'b1, A_CORNER, B_SP, 3'd4, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd11: u = mk_uop(1'b1, A_CORNER, B_NSP, 3'd6, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd12: u = mk_uop(1'b1, A_CORNER, B_NSM, 3'd1, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd13: u = mk_uop(1'b1, A_CORNER, B_SM, 3'd3, ACC_SET, WR_DXDT, 2'd0, FL_NEXT);
      5'd14: u = mk_uop(1'b1, A_CORNER, B_SP, 3'd5, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd15: u = mk_uop(1'b1, A_CORNER, B_NSP, 3'd7, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd16: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_ADD, WR_NONE, 2'd0, FL_NEXT);
      5'd17: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_DYDT, 2'd0, FL_NEXT);
      5'd18: u = mk_uop(1'b1, A_DXDS, B_DYDT, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_NEXT);
      5'd19: u = mk_uop(1'b1, A_DYDS, B_DXDT, 3'd0, ACC_NONE, WR_DET_SET, 2'd0, FL_NEXT);
      5'd20: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_DET_SUB, 2'd0, FL_NEXT);
      5'd21: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_DETCHK);
      5'd22: u = mk_uop(1'b1, A_X, B_DYDT, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_NEXT);
      5'd23: u = mk_uop(1'b1, A_Y, B_DXDT, 3'd0, ACC_NONE, WR_NS_SET, 2'd0, FL_NEXT);
      5'd24: u = mk_uop(1'b1, A_DXDS, B_Y, 3'd0, ACC_NONE, WR_NS_SUB, 2'd0, FL_NEXT);
      5'd25: u = mk_uop(1'b1, A_DYDS, B_X, 3'd0, ACC_NONE, WR_NT_SET, 2'd0, FL_NEXT);
      5'd26: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_NT_SUB, 2'd0, FL_NEXT);
      5'd27: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_DIV_S);
      5'd28: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_UPD_S, 2'd0, FL_NEXT);
      5'd29: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_DIV_T);
      5'd30: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_UPD_T, 2'd0, FL_NEXT);
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

  // squared residual and the stop test
  function automatic uop_t err_uop(input logic [1:0] e);
    uop_t u;
    case (e)
      2'd0: u = mk_uop(1'b1, A_X, B_X, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_NEXT);
      2'd1: u = mk_uop(1'b1, A_Y, B_Y, 3'd0, ACC_NONE, WR_ERR_SET, 2'd0, FL_NEXT);
      2'd2: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_ERR_ADD, 2'd0, FL_NEXT);
      default: u = mk_uop(1'b0, A_X, B_X, 3'd0, ACC_NONE, WR_NONE, 2'd0, FL_ERRCHK);
    endcase
    return u;
  endfunction

  function automatic uop_t ibq_ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    logic [PC_W-1:0] off;
    off = 7'd0;
    if (pc < PC_JAC) begin
      u = res_uop(pc[3:0]);
    end else if (pc < PC_RES2) begin
      off = pc - PC_JAC;
      u = jac_uop(off[4:0]);
    end else if (pc < PC_ERR) begin
      off = pc - PC_RES2;
      u = res_uop(off[3:0]);
    end else begin
      off = pc - PC_ERR;
      u = err_uop(off[1:0]);
    end
    return u;
  endfunction

endpackage

[rtl/core/ibq_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_div
// bit-serial restoring divider: (num << FRAC_BITS) / den, saturated to 32 bits
// ----------------------------------------------------------------------------
module ibq_div import ibq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WIDE_W-1:0] num_i,
  input  logic signed [WIDE_W-1:0] den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] quo_o
);

  localparam int unsigned STEPS = WIDE_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WIDE_W-1:0] un_q, ud_q, r_q;
  logic [DATA_W-1:0] q_q;
  logic              sat_q, neg_q;
  logic [WIDE_W-1:0] r_sh, r_n;
  logic              ge;
  logic [DATA_W:0]   q_sh;

  assign r_sh = {r_q[WIDE_W-2:0], un_q[WIDE_W-1]};
  assign ge   = (r_sh >= ud_q);
  assign r_n  = ge ? (r_sh - ud_q) : r_sh;
  assign q_sh = {q_q, ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST) busy_q <= 1'b0;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      un_q  <= num_i[WIDE_W-1] ? (WIDE_W'(0) - num_i) : num_i;
      ud_q  <= den_i[WIDE_W-1] ? (WIDE_W'(0) - den_i) : den_i;
      neg_q <= num_i[WIDE_W-1] ^ den_i[WIDE_W-1];
      r_q   <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      un_q <= {un_q[WIDE_W-2:0], 1'b0};
      r_q  <= r_n;
      q_q  <= q_sh[DATA_W-1:0];
      if (q_sh[DATA_W]) sat_q <= 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == LAST);

  always_comb begin
    if (neg_q) begin
      if (sat_q || (q_q > 32'h8000_0000)) quo_o = 32'sh8000_0000;
      else quo_o = $signed(32'd0 - q_q);
    end else begin
      if (sat_q || q_q[DATA_W-1]) quo_o = 32'sh7fff_ffff;
      else quo_o = $signed(q_q);
    end
  end

endmodule

[rtl/core/ibq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_datapath
// corner registers, shared multiplier, accumulator, working registers, divider
// ----------------------------------------------------------------------------
module ibq_datapath import ibq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 20,
  parameter int unsigned ERR_TOL   = 10,
  parameter int unsigned DET_MIN   = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [DATA_W-1:0]          cfg_data_i,
  input  logic signed [DATA_W-1:0]   point_x_i,
  input  logic signed [DATA_W-1:0]   point_y_i,
  input  dp_cmd_t                    cmd_i,
  output dp_stat_t                   stat_o,
  output logic signed [DATA_W-1:0]   coord_s_o,
  output logic signed [DATA_W-1:0]   coord_t_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ITER_W-1:0]          iterations_o
);

  localparam logic [WIDE_W-1:0] TOL2    = WIDE_W'(ERR_TOL) * WIDE_W'(ERR_TOL);
  localparam logic [WIDE_W-1:0] DET_LIM = WIDE_W'(DET_MIN) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ONE_Q = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] HALF_Q = 32'sd1 <<< (FRAC_BITS - 1);

  logic signed [DATA_W-1:0] corner_q [NUM_CORNER_REGS];
  logic signed [DATA_W-1:0] w_q [4];
  logic signed [DATA_W-1:0] px_q, py_q, s_q, t_q, sp_q, sm_q, tp_q, tm_q;
  logic signed [DATA_W-1:0] x_q, y_q, dxds_q, dyds_q, dxdt_q, dydt_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [WIDE_W-1:0] det_q, ns_q, nt_q;
  logic [WIDE_W-1:0]        err_q;
  logic signed [DATA_W-1:0] res_s_q, res_t_q;
  logic [STATUS_W-1:0]      res_status_q;
  logic [ITER_W-1:0]        res_iter_q;

  uop_t                     u;
  logic signed [OPND_W-1:0] a_op, b_op;
  logic signed [DATA_W-1:0] q_val, shape_val, res_x, res_y, quo;
  logic signed [ACC_W-1:0]  q_ext;
  logic [WIDE_W-1:0]        det_mag;
  logic                     div_done, div_busy;

  assign u = cmd_i.uop;

  function automatic logic signed [OPND_W-1:0] ex(input logic signed [DATA_W-1:0] v);
    return $signed({v[DATA_W-1], v});
  endfunction

  // operand selection for the shared multiplier
  always_comb begin
    unique case (u.a_sel)
      A_CORNER: a_op = ex(corner_q[u.cidx]);
      A_SM:     a_op = ex(sm_q);
      A_SP:     a_op = ex(sp_q);
      A_X:      a_op = ex(x_q);
      A_Y:      a_op = ex(y_q);
      A_DXDS:   a_op = ex(dxds_q);
      A_DYDS:   a_op = ex(dyds_q);
      default:  a_op = ex(x_q);
    endcase
    unique case (u.b_sel)
      B_TM:    b_op = ex(tm_q);
      B_TP:    b_op = ex(tp_q);
      B_NTM:   b_op = -ex(tm_q);
      B_NTP:   b_op = -ex(tp_q);
      B_SM:    b_op = ex(sm_q);
      B_NSM:   b_op = -ex(sm_q);
      B_SP:    b_op = ex(sp_q);
      B_NSP:   b_op = -ex(sp_q);
      B_W:     b_op = ex(w_q[u.cidx[2:1]]);
      B_DYDT:  b_op = ex(dydt_q);
      B_DXDT:  b_op = ex(dxdt_q);
      B_X:     b_op = ex(x_q);
      B_Y:     b_op = ex(y_q);
      default: b_op = ex(x_q);
    endcase
  end

  // fixed point rescale of the last product, shape sum /4, residuals
  assign q_val     = sat32(p_q >>> FRAC_BITS);
  assign q_ext     = $signed({{(ACC_W-DATA_W){q_val[DATA_W-1]}}, q_val});
  assign shape_val = sat32($signed({{(PROD_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}) >>> 2);
  assign res_x     = sat32(ext66(shape_val) - ext66(px_q));
  assign res_y     = sat32(ext66(shape_val) - ext66(py_q));

  assign det_mag = det_q[WIDE_W-1] ? (WIDE_W'(0) - det_q) : det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CORNER_REGS; i++) corner_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_CORNER_REGS))) begin
      corner_q[cfg_idx_i[2:0]] <= $signed(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      s_q  <= HALF_Q;
      t_q  <= HALF_Q;
    end
    if (u.mul_en) p_q <= a_op * b_op;
    case (u.acc_op)
      ACC_SET: acc_q <= q_ext;
      ACC_ADD: acc_q <= acc_q + q_ext;
      default: ;
    endcase
    unique case (u.wr_op)
      WR_FACT: begin
        sp_q <= sat32(ONE_Q + ext66(s_q));
        sm_q <= sat32(ONE_Q - ext66(s_q));
        tp_q <= sat32(ONE_Q + ext66(t_q));
        tm_q <= sat32(ONE_Q - ext66(t_q));
      end
      WR_W:       w_q[u.widx] <= q_val;
      WR_X:       x_q <= res_x;
      WR_Y:       y_q <= res_y;
      WR_DXDS:    dxds_q <= shape_val;
      WR_DYDS:    dyds_q <= shape_val;
      WR_DXDT:    dxdt_q <= shape_val;
      WR_DYDT:    dydt_q <= shape_val;
      WR_DET_SET: det_q <= p_q[WIDE_W-1:0];
      WR_DET_SUB: det_q <= det_q - p_q[WIDE_W-1:0];
      WR_NS_SET:  ns_q <= p_q[WIDE_W-1:0];
      WR_NS_SUB:  ns_q <= ns_q - p_q[WIDE_W-1:0];
      WR_NT_SET:  nt_q <= p_q[WIDE_W-1:0];
      WR_NT_SUB:  nt_q <= nt_q - p_q[WIDE_W-1:0];
      WR_ERR_SET: err_q <= p_q[WIDE_W-1:0];
      WR_ERR_ADD: err_q <= err_q + p_q[WIDE_W-1:0];
      WR_UPD_S:   s_q <= sat32(ext66(s_q) - ext66(quo));
      WR_UPD_T:   t_q <= sat32(ext66(t_q) - ext66(quo));
      default: ;
    endcase
    if (cmd_i.cap) begin
      res_s_q      <= s_q;
      res_t_q      <= t_q;
      res_status_q <= cmd_i.status;
      res_iter_q   <= cmd_i.iter;
    end
  end

  ibq_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_sel ? nt_q : ns_q),
    .den_i   (det_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign stat_o.det_bad  = (det_q == '0) || (det_mag < DET_LIM);
  assign stat_o.err_ok   = (err_q <= TOL2);
  assign stat_o.div_done = div_done;
  assign stat_o.div_busy = div_busy;

  assign coord_s_o    = res_s_q;
  assign coord_t_o    = res_t_q;
  assign status_o     = res_status_q;
  assign iterations_o = res_iter_q;

endmodule

[rtl/core/ibq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_ctrl
// sequencer: walks the step sequence, branches on the datapath status
// ----------------------------------------------------------------------------
module ibq_ctrl import ibq_pkg::*; #(
  parameter int unsigned MAX_ITER = 50
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;
  uop_t                cur;

  assign cur = ibq_ucode(pc_q);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    iter_d      = iter_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.uop   = UOP_NOP;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = '0;
          iter_d     = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.uop = cur;
        pc_d      = pc_q + 1'b1;
        unique case (cur.flow) inside
          FL_DETCHK: begin
            if (stat_i.det_bad) begin
              status_d = RES_SINGULAR;
              state_d  = S_FIN;
            end
          end
          FL_DIV_S, FL_DIV_T: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = (cur.flow == FL_DIV_T);
            state_d         = S_DIVW;
          end
          FL_ERRCHK: begin
            iter_d = iter_q + 1'b1;
            if (stat_i.err_ok) begin
              status_d = RES_CONVERGED;
              state_d  = S_FIN;
            end else if (iter_d >= ITER_W'(MAX_ITER)) begin
              status_d = RES_LIMIT;
              state_d  = S_FIN;
            end else begin
              pc_d = PC_JAC;
            end
          end
          default: ;
        endcase
      end
      S_DIVW: begin
        if (stat_i.div_done) state_d = S_RUN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.cap    = 1'b1;
          cmd_o.status = status_q;
          cmd_o.iter   = iter_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      iter_q      <= '0;
      status_q    <= RES_CONVERGED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      iter_q      <= iter_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy)
    else $error("division started while divider busy");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= ITER_W'(MAX_ITER))
    else $error("step count beyond limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |-> !(out_valid_q && out_stall_i))
    else $error("result captured over a pending item");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_DIVW))
    else $error("divider finished while not awaited");

endmodule

[rtl/core/inverse_bilinear_quad_coords_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_bilinear_quad_coords_top
// isoparametric (s,t) of a point in a quad by newton steps, signed fixed point
// ----------------------------------------------------------------------------
// The block takes one point at a time and returns its (s,t), a status and the
// number of newton steps. A step ends early when the jacobian is found
// singular. The bit-serial divider produces one quotient bit a cycle and runs
// twice a step; the single shared 33x33 multiplier is driven by the sequencer
// once a cycle while it runs, not while it waits on the divider. A new item is
// taken once the previous one has been moved into the output register; the
// result waits there until taken. The user must write the corner registers
// through the plain write port only while idle; the block itself does not
// enforce it. Indexes beyond the eight corners are ignored.
// ----------------------------------------------------------------------------
module inverse_bilinear_quad_coords_top import ibq_pkg::*; #(
  parameter int unsigned MAX_ITER  = 50,
  parameter int unsigned FRAC_BITS = 20,
  parameter int unsigned ERR_TOL   = 10,
  parameter int unsigned DET_MIN   = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] point_x_i,
  input  logic signed [DATA_W-1:0] point_y_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] coord_s_o,
  output logic signed [DATA_W-1:0] coord_t_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [ITER_W-1:0]        iterations_o
);

  // commands from the sequencer, status back from the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ibq_ctrl #(
    .MAX_ITER (MAX_ITER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ibq_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ERR_TOL   (ERR_TOL),
    .DET_MIN   (DET_MIN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .coord_s_o    (coord_s_o),
    .coord_t_o    (coord_t_o),
    .status_o     (status_o),
    .iterations_o (iterations_o)
  );

endmodule
